// ===== design/lkvc_pkg.sv =====
// lkvc_pkg: shared constants and types of the lru key-value cache
// used by the cache rtl, no dependencies
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int unsigned ENTRIES_DEF     = 16;
  localparam int unsigned KEY_WIDTH_DEF   = 32;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // request operation codes; the spare code behaves as a probe
  typedef enum logic [1:0] {
    OP_GET   = 2'd0,
    OP_PUT   = 2'd1,
    OP_PROBE = 2'd2,
    OP_SPARE = 2'd3
  } op_e;

  // per-cell update control
  typedef struct packed {
    logic load;   // take the head entry (cell 0 only)
    logic shift;  // take the entry of the more recent neighbor
  } cell_ctl_t;

endpackage

// ===== design/lkvc_cell.sv =====
// lkvc_cell: one slot of the recency-ordered chain (key, value, valid)
// depends on lkvc_pkg for the control struct
`timescale 1ns / 1ps

module lkvc_cell #(
  parameter int unsigned KEY_WIDTH   = lkvc_pkg::KEY_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lkvc_pkg::cell_ctl_t    ctl_i,
  input  logic [KEY_WIDTH-1:0]   head_key_i,
  input  logic [VALUE_WIDTH-1:0] head_value_i,
  input  logic [KEY_WIDTH-1:0]   prev_key_i,
  input  logic [VALUE_WIDTH-1:0] prev_value_i,
  input  logic                   prev_valid_i,
  output logic [KEY_WIDTH-1:0]   key_o,
  output logic [VALUE_WIDTH-1:0] value_o,
  output logic                   valid_o
);

  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic                   valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.load) begin
      valid_q <= 1'b1;
    end else if (ctl_i.shift) begin
      valid_q <= prev_valid_i;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      key_q   <= head_key_i;
      value_q <= head_value_i;
    end else if (ctl_i.shift) begin
      key_q   <= prev_key_i;
      value_q <= prev_value_i;
    end
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

// ===== design/lru_key_value_cache.sv =====
// lru_key_value_cache: fully associative lru key-value cache, top level
// depends on lkvc_pkg and lkvc_cell
`timescale 1ns / 1ps

// channel   dir  signals                          item
// s_axis    in   s_tvalid_i s_tready_o s_tdata_i  request: tuser = operation
// m_axis    out  m_tvalid_o m_tready_i m_tdata_o  result: hit, read_value, occupancy
// cfg       in   cfg_valid_i cfg_ready_o cfg_data_i  capacity write
//
// each request passes a lookup state (parallel key compare over all cells) and
// an apply state (on a get hit or a put the cell chain shifts by one toward
// least recent); a new request is taken in the apply state of the previous one
// reset empties the chain at once (valid bits only) and sets capacity to 16
// a result waiting in the output register stalls the apply cycle only

module lru_key_value_cache #(
  parameter int unsigned ENTRIES     = lkvc_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_WIDTH   = lkvc_pkg::KEY_WIDTH_DEF,
  parameter int unsigned VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request: tdata = lookup_key[31:0], write_value[63:32]
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [63:0] s_tdata_i,
  // request kind: tuser = operation[1:0]
  input  logic [1:0]  s_tuser_i,
  // result: tdata = hit[0], read_value[32:1], occupancy[37:33], zero pad[39:38]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [39:0] m_tdata_o,
  // capacity register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_LOOK  = 3'b010,
    ST_APPLY = 3'b100
  } state_e;

  state_e state_q, state_d;

  // capacity register
  logic [4:0] cap_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 5'd16;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end
  assign cfg_ready_o = 1'b1;

  // capacity clamped to 1 .. ENTRIES
  logic [31:0] eff_cap;
  always_comb begin
    if (cap_q == 5'd0) begin
      eff_cap = 32'd1;
    end else if (32'(cap_q) > 32'(ENTRIES)) begin
      eff_cap = 32'(ENTRIES);
    end else begin
      eff_cap = 32'(cap_q);
    end
  end

  // request registers
  lkvc_pkg::op_e          op_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] wval_q;
  logic                   s_acc;

  assign s_acc = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      op_q   <= lkvc_pkg::op_e'(s_tuser_i);
      key_q  <= KEY_WIDTH'(s_tdata_i[31:0]);
      wval_q <= VALUE_WIDTH'(s_tdata_i[63:32]);
    end
  end

  // cell chain, cell 0 most recent
  logic [KEY_WIDTH-1:0]   cell_key   [ENTRIES];
  logic [VALUE_WIDTH-1:0] cell_value [ENTRIES];
  logic [ENTRIES-1:0]     cell_valid;
  lkvc_pkg::cell_ctl_t    cell_ctl   [ENTRIES];

  logic [CW-1:0] count_q, count_d;

  // lookup cycle: parallel compare, one-hot match since valid keys are distinct
  logic [ENTRIES-1:0]     match;
  logic [IW-1:0]          hit_idx;
  logic [VALUE_WIDTH-1:0] hit_value;
  logic                   hit;
  logic                   full;

  always_comb begin
    hit_idx   = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = cell_valid[i] && (cell_key[i] == key_q);
      if (match[i]) begin
        hit_idx   = hit_idx | IW'(i);
        hit_value = hit_value | cell_value[i];
      end
    end
    hit  = |match;
    full = 32'(count_q) >= eff_cap;
  end

  // lookup results for the apply cycle
  logic                   upd_q;     // chain changes
  logic                   inc_q;     // new entry without eviction
  logic [CW-1:0]          limit_q;   // last cell that takes its neighbor
  logic [KEY_WIDTH-1:0]   head_key_q;
  logic [VALUE_WIDTH-1:0] head_val_q;
  logic                   hit_q;
  logic [VALUE_WIDTH-1:0] rdv_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOOK) begin
      hit_q      <= hit;
      head_key_q <= key_q;
      rdv_q      <= '0;
      upd_q      <= 1'b0;
      inc_q      <= 1'b0;
      limit_q    <= CW'(hit_idx);
      head_val_q <= hit_value;
      case (op_q)
        lkvc_pkg::OP_GET: begin
          if (hit) begin
            upd_q <= 1'b1;
            rdv_q <= hit_value;
          end
        end
        lkvc_pkg::OP_PUT: begin
          upd_q      <= 1'b1;
          head_val_q <= wval_q;
          if (!hit) begin
            // new key: evict the last valid cell when at capacity
            if (full) begin
              limit_q <= count_q - CW'(1);
            end else begin
              limit_q <= count_q;
              inc_q   <= 1'b1;
            end
          end
        end
        default: begin
          // probe and the spare code leave the chain alone
        end
      endcase
    end
  end

  // apply cycle goes ahead once the output register has room
  logic m_valid_q;
  logic apply_go;

  assign apply_go   = (state_q == ST_APPLY) && (!m_valid_q || m_tready_i);
  assign s_tready_o = (state_q == ST_IDLE) || apply_go;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      cell_ctl[i].load  = (i == 0) && apply_go && upd_q;
      cell_ctl[i].shift = (i != 0) && apply_go && upd_q && (32'(i) <= 32'(limit_q));
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      lkvc_cell #(
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctl_i        (cell_ctl[g]),
        .head_key_i   (head_key_q),
        .head_value_i (head_val_q),
        .prev_key_i   ('0),
        .prev_value_i ('0),
        .prev_valid_i (1'b0),
        .key_o        (cell_key[g]),
        .value_o      (cell_value[g]),
        .valid_o      (cell_valid[g])
      );
    end else begin : g_body
      lkvc_cell #(
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctl_i        (cell_ctl[g]),
        .head_key_i   (head_key_q),
        .head_value_i (head_val_q),
        .prev_key_i   (cell_key[g-1]),
        .prev_value_i (cell_value[g-1]),
        .prev_valid_i (cell_valid[g-1]),
        .key_o        (cell_key[g]),
        .value_o      (cell_value[g]),
        .valid_o      (cell_valid[g])
      );
    end
  end

  // occupancy
  assign count_d = (apply_go && inc_q) ? count_q + CW'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (apply_go) begin
          state_d = s_tvalid_i ? ST_LOOK : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // output register
  logic        out_hit_q;
  logic [31:0] out_rdv_q;
  logic [4:0]  out_occ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (apply_go) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply_go) begin
      out_hit_q <= hit_q;
      out_rdv_q <= 32'(rdv_q);
      out_occ_q <= 5'(count_d);
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {2'b00, out_occ_q, out_rdv_q, out_hit_q};

endmodule
